// ----- design/gfvpe_pkg.sv -----
// Shared types, constants and GF(256) helpers of the Vandermonde parity encoder.
package gfvpe_pkg;

   localparam int DEF_MAX_FRAME_BYTES = 2048;
   localparam int DEF_MAX_PARITY_ROWS = 4;
   localparam int DEF_MAX_DATA_FRAMES = 255;

   localparam logic [8:0] FIELD_POLY  = 9'h11D;
   localparam logic [9:0] GROUP_ORDER = 10'd255;

   // result queue depth, in finished positions
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] REG_PARITY_ROWS  = 2'd0;
   localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;

   localparam logic [2:0]  RESET_PARITY_ROWS  = 3'd2;
   localparam logic [11:0] RESET_FRAME_LENGTH = 12'd2048;

   typedef logic [7:0] byte_table_type [0:255];

   // word entering the lanes in the accept cycle
   typedef struct packed {
      logic        valid;
      logic [7:0]  frame_index;
      logic [10:0] position;
   } issue_type;

   // word in the read-modify-write stage
   typedef struct packed {
      logic        valid;
      logic        first;
      logic        final_frame;
      logic [7:0]  data_byte;
      logic [10:0] position;
   } stage_type;

   function automatic byte_table_type build_exp_table();
      byte_table_type t;
      logic [8:0] v;
      v = 9'd1;
      for (int i = 0; i < 256; i++) begin
         t[i] = v[7:0];
         v = {v[7:0], 1'b0};
         if (v[8]) begin
            v = v ^ FIELD_POLY;
         end
      end
      return t;
   endfunction

   localparam byte_table_type EXP_TABLE = build_exp_table();

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'd0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'd0);
      end
      return acc;
   endfunction

endpackage

// ----- design/gf256_vandermonde_parity_encoder.sv -----
// Top level of the GF(256) Vandermonde erasure parity encoder.
//
// req_ carries data bytes tagged with frame index and byte position; req_tlast
// marks a byte of the final frame. Each accepted word reads the parity bank of
// every row at its position, and in the cycle after that the banks are written back
// with the byte times alpha^(j*d) added in (a byte of frame 0 overwrites).
// A word is taken every cycle while the queue has room; back-to-back words on
// one position are forwarded around the registered bank read.
// A final-frame word queues its K parity bytes, which leave on rsp_ one row
// per word, row 0 first, rsp_tlast on row K-1; the first row appears once the
// word has passed the update stage and been written into the queue. A final-frame
// stream is thus limited by the result channel, which sends K rows per position.
// A queue of four positions decouples the sides: while the receiver stalls
// rsp_, req_ keeps going until the queue has no room left for final words.
// Words with a row count outside 2..MAX_PARITY_ROWS, a position at or beyond
// frame_length or a frame index of MAX_DATA_FRAMES or more are dropped.
// csr_ writes the row count K (index 0) or frame_length (index 1); it is always
// ready. Reset empties the queue and restores the register defaults; the
// parity banks are not cleared, frame 0 of each stripe fills them.
module gf256_vandermonde_parity_encoder #(
   parameter int MAX_FRAME_BYTES = gfvpe_pkg::DEF_MAX_FRAME_BYTES,
   parameter int MAX_PARITY_ROWS = gfvpe_pkg::DEF_MAX_PARITY_ROWS,
   parameter int MAX_DATA_FRAMES = gfvpe_pkg::DEF_MAX_DATA_FRAMES
) (
   input  logic        clock,
   input  logic        reset,
   // data_byte, frame_index, byte_position, zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   // parity_byte, row index, out_position, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import gfvpe_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [16:0] MAX_BYTES17 = 17'(MAX_FRAME_BYTES);

   logic [2:0]  rows_ff, rows_in;
   logic [11:0] flen_ff, flen_in;
   logic [7:0]  in_byte;
   logic [7:0]  in_frame;
   logic [10:0] in_pos;
   logic [16:0] flen_ext;
   logic [16:0] limit;
   logic        rows_ok, pos_ok, frame_ok, item_ok;
   logic        accept;
   issue_type   issue;
   stage_type   s1_ff, s1_in;
   logic        s1_push;
   logic [CW-1:0] q_count;
   logic [MAX_PARITY_ROWS-1:0]      row_en;
   logic [MAX_PARITY_ROWS-1:0][7:0] lane_value;

   assign in_byte  = req_tdata[7:0];
   assign in_frame = req_tdata[15:8];
   assign in_pos   = req_tdata[26:16];

   assign csr_ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      flen_in = flen_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PARITY_ROWS:  rows_in = csr_data[2:0];
            REG_FRAME_LENGTH: flen_in = csr_data;
            default:          rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RESET_PARITY_ROWS;
         flen_ff <= RESET_FRAME_LENGTH;
         s1_ff   <= '0;
      end else begin
         rows_ff <= rows_in;
         flen_ff <= flen_in;
         s1_ff   <= s1_in;
      end
   end

   always_comb begin
      flen_ext = {5'd0, flen_ff};
      limit    = (flen_ext > MAX_BYTES17) ? MAX_BYTES17 : flen_ext;
      rows_ok  = (rows_ff >= 3'd2) && (int'(rows_ff) <= MAX_PARITY_ROWS);
      pos_ok   = {6'd0, in_pos} < limit;
      frame_ok = {1'b0, in_frame} < 9'(MAX_DATA_FRAMES);
      item_ok  = rows_ok & pos_ok & frame_ok;
   end

   // hold input while the queue could not take every final word in flight
   assign s1_push    = s1_ff.valid & s1_ff.final_frame;
   assign req_tready = (int'(q_count) + int'(s1_push)) < QUEUE_DEPTH;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      issue.valid       = accept & item_ok;
      issue.frame_index = in_frame;
      issue.position    = in_pos;
      s1_in.valid       = accept & item_ok;
      s1_in.first       = (in_frame == 8'd0);
      s1_in.final_frame = req_tlast;
      s1_in.data_byte   = in_byte;
      s1_in.position    = in_pos;
   end

   for (genvar j = 0; j < MAX_PARITY_ROWS; j++) begin : g_lane
      assign row_en[j] = int'(rows_ff) > j;
      gfvpe_lane #(
         .ROW             (j),
         .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .issue  (issue),
         .stage  (s1_ff),
         .row_en (row_en[j]),
         .value  (lane_value[j])
      );
   end

   gfvpe_outq #(
      .MAX_PARITY_ROWS (MAX_PARITY_ROWS)
   ) u_outq (
      .clock         (clock),
      .reset         (reset),
      .push          (s1_push),
      .push_bytes    (lane_value),
      .push_position (s1_ff.position),
      .row_count     (rows_ff),
      .count         (q_count),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_push |-> (int'(q_count) < QUEUE_DEPTH) || (rsp_tvalid && rsp_tready && rsp_tlast))
      else $error("result queue overflow");

   a_drop_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && !item_ok) |=> !s1_ff.valid)
      else $error("ignored word entered the update stage");

   a_rows_remain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("position left the queue before its last row");

endmodule

// ----- design/gfvpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gfvpe_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gfvpe_lane.sv -----
// One parity row: coefficient lookup, parity bank and read-modify-write with forwarding.
module gfvpe_lane #(
   parameter int ROW             = 0,
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  gfvpe_pkg::issue_type issue,
   input  gfvpe_pkg::stage_type stage,
   input  logic                row_en,
   output logic [7:0]          value
);
   import gfvpe_pkg::*;

   localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

   logic [9:0]  exp_raw;
   logic [9:0]  exp_once;
   logic [9:0]  exp_red;
   logic [7:0]  coef_in, coef_ff;
   logic        fwd_in, fwd_ff;
   logic [7:0]  fwd_data_ff;
   logic [16:0] rd_pos_ext, wr_pos_ext;
   logic [7:0]  rd_data;
   logic [7:0]  old_value;
   logic [7:0]  term;
   logic        wr_en;

   // j*d mod 255, with j*d below three times the group order
   always_comb begin
      exp_raw  = 10'(ROW) * {2'b00, issue.frame_index};
      exp_once = (exp_raw >= GROUP_ORDER) ? exp_raw - GROUP_ORDER : exp_raw;
      exp_red  = (exp_once >= GROUP_ORDER) ? exp_once - GROUP_ORDER : exp_once;
      coef_in  = EXP_TABLE[exp_red[7:0]];
   end

   assign wr_en      = stage.valid & row_en;
   assign rd_pos_ext = {6'd0, issue.position};
   assign wr_pos_ext = {6'd0, stage.position};

   // the bank read in the same cycle as a write to that entry returns stale data
   assign fwd_in = issue.valid & wr_en & (issue.position == stage.position);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
      coef_ff     <= coef_in;
      fwd_data_ff <= value;
   end

   assign old_value = fwd_ff ? fwd_data_ff : rd_data;
   assign term      = gf_mul(coef_ff, stage.data_byte);
   assign value     = stage.first ? term : (old_value ^ term);

   gfvpe_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_bank (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_pos_ext[AW-1:0]),
      .wr_data (value),
      .rd_addr (rd_pos_ext[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

// ----- design/gfvpe_outq.sv -----
// Queue of finished parity positions and the row-by-row serializer onto the result channel.
module gfvpe_outq #(
   parameter int MAX_PARITY_ROWS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [MAX_PARITY_ROWS-1:0][7:0]  push_bytes,
   input  logic [10:0]                      push_position,
   input  logic [2:0]                       row_count,
   output logic [$clog2(gfvpe_pkg::QUEUE_DEPTH+1)-1:0] count,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,
   output logic                             rsp_tlast
);
   import gfvpe_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = (MAX_PARITY_ROWS > 1) ? $clog2(MAX_PARITY_ROWS) : 1;

   logic [MAX_PARITY_ROWS-1:0][7:0] bytes_ff [QUEUE_DEPTH];
   logic [10:0]                     pos_ff   [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    row_ff, row_in;
   logic          last_row;
   logic          take;
   logic          pop;
   logic [7:0]    out_byte;

   assign rsp_tvalid = (count_ff != '0);
   assign last_row   = ({1'b0, row_ff} + 3'd1) == row_count;
   assign take       = rsp_tvalid & rsp_tready;
   assign pop        = take & last_row;
   assign out_byte   = bytes_ff[rd_ptr_ff][row_ff[RW-1:0]];

   // parity_byte, row index, out_position, zero fill
   assign rsp_tdata = {3'd0, pos_ff[rd_ptr_ff], row_ff, out_byte};
   assign rsp_tlast = last_row;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      row_in    = row_ff;
      if (push) begin
         wr_ptr_in = PW'((int'(wr_ptr_ff) + 1) % QUEUE_DEPTH);
      end
      if (take) begin
         row_in = last_row ? 2'd0 : row_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = PW'((int'(rd_ptr_ff) + 1) % QUEUE_DEPTH);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         row_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         row_ff    <= row_in;
      end
      if (push) begin
         bytes_ff[wr_ptr_ff] <= push_bytes;
         pos_ff[wr_ptr_ff]   <= push_position;
      end
   end

endmodule
